[rtl/efr_pkg.sv]
// Shared types and constants for the escaped frame receiver.
`timescale 1ns / 1ps
package efr_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int EFR_QDEPTH      = 4;
    localparam int QPTR_W          = $clog2(EFR_QDEPTH);
    localparam int QCNT_W          = $clog2(EFR_QDEPTH + 1);

    localparam logic [7:0]  SYM_ESC   = 8'hAA;
    localparam logic [7:0]  SYM_HDR   = 8'h55;
    localparam logic [7:0]  SYM_LIT   = 8'h01;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    // Event codes; the front part uses EK_GOOD for "frame end, check the CRC".
    typedef enum logic [2:0] {
        EK_DATA    = 3'd0,
        EK_GOOD    = 3'd1,
        EK_CRCERR  = 3'd2,
        EK_RESTART = 3'd3,
        EK_OVF     = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [8:0]  idx;
        logic        last;
    } t_evt;

endpackage

[rtl/efr_fifo.sv]
// Small register queue of events with push/full and pop/empty sides.
`timescale 1ns / 1ps
module efr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  efr_pkg::t_evt i_data,
    output logic          o_full,
    input  logic          i_pop,
    output efr_pkg::t_evt o_data,
    output logic          o_empty
);
    import efr_pkg::*;

    t_evt              r_mem [EFR_QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push, w_pop;

    assign o_full  = (r_cnt == QCNT_W'(EFR_QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !(r_cnt == '0))
        else $error("queue drained from full without pops");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a push");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(EFR_QDEPTH))
        else $error("queue count beyond depth");

endmodule

[rtl/efr_front.sv]
// Front part: header hunt, unescape, byte counting and event classification.
`timescale 1ns / 1ps
module efr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_rx_byte,
    output logic          o_full,
    output logic          o_op_push,
    output efr_pkg::t_evt o_op,
    input  logic          i_op_full
);
    import efr_pkg::*;

    typedef enum logic [1:0] {
        H_WAIT_AA,
        H_WAIT_55,
        H_FRAME
    } t_hunt;

    typedef struct packed {
        t_hunt      hunt;
        logic       pend;
        logic [8:0] cnt;
        logic [7:0] len;
    } t_fst;

    typedef struct packed {
        t_fst       st;
        t_evt       e0;
        t_evt       e1;
        logic       two;
        logic [1:0] r;
    } t_dres;

    function automatic t_fst f_clear(t_fst s);
        t_fst o;
        o      = s;
        o.pend = 1'b0;
        o.cnt  = '0;
        o.len  = '0;
        return o;
    endfunction

    function automatic t_fst f_hunt(t_fst s, logic [7:0] b);
        t_fst o;
        o = s;
        if (s.hunt == H_WAIT_55) begin
            if (b == SYM_HDR) begin
                o      = f_clear(s);
                o.hunt = H_FRAME;
            end else if (b != SYM_ESC) begin
                o.hunt = H_WAIT_AA;
            end
        end else begin
            o.hunt = (b == SYM_ESC) ? H_WAIT_55 : H_WAIT_AA;
        end
        return o;
    endfunction

    // Decode one byte: r is 0 to go on, 1 on frame end, 2 on overflow.
    function automatic t_dres f_decode(t_fst s, logic [7:0] v);
        t_dres      d;
        logic [9:0] c1;
        d     = '0;
        d.st  = s;
        c1    = {1'b0, s.cnt} + 10'd1;
        if ({1'b0, s.cnt} >= 10'(MAX_FRAME_BYTES)) begin
            d.e0      = '{kind: EK_OVF, data: 8'h00, idx: s.cnt, last: 1'b0};
            d.st      = f_clear(s);
            d.st.hunt = H_WAIT_AA;
            d.r       = 2'd2;
        end else begin
            d.e0 = '{kind: EK_DATA, data: v, idx: s.cnt, last: 1'b0};
            if (s.cnt == '0) d.st.len = v;
            d.st.cnt = c1[8:0];
            if (c1 >= 10'd3 && c1 == ({2'b00, d.st.len} + 10'd3)) begin
                d.e1      = '{kind: EK_GOOD, data: 8'h00, idx: c1[8:0], last: 1'b0};
                d.two     = 1'b1;
                d.st      = f_clear(d.st);
                d.st.hunt = H_WAIT_AA;
                d.r       = 2'd1;
            end
        end
        return d;
    endfunction

    t_fst       r_st, n_st;
    t_evt       r_ops [3];
    t_evt       n_ops [3];
    logic [1:0] r_left, n_left;
    logic [1:0] r_ptr;
    logic       w_accept, w_drain;

    always_comb begin
        t_fst       s;
        t_dres      d;
        logic       do_b;
        logic [1:0] n;
        s     = r_st;
        d     = '0;
        do_b  = 1'b1;
        n     = '0;
        n_ops = '{default: '0};
        if (r_st.hunt == H_FRAME) begin
            if (s.pend) begin
                s.pend = 1'b0;
                if (i_rx_byte == SYM_LIT) begin
                    d = f_decode(s, SYM_ESC);
                    s = d.st;
                    n_ops[n] = d.e0;
                    n = n + 2'd1;
                    if (d.two) begin
                        n_ops[n] = d.e1;
                        n = n + 2'd1;
                    end
                    do_b = 1'b0;
                end else if (i_rx_byte == SYM_HDR) begin
                    n_ops[n] = '{kind: EK_RESTART, data: 8'h00, idx: s.cnt, last: 1'b0};
                    n = n + 2'd1;
                    s = f_clear(s);
                    do_b = 1'b0;
                end else begin
                    d = f_decode(s, SYM_ESC);
                    s = d.st;
                    n_ops[n] = d.e0;
                    n = n + 2'd1;
                    if (d.two) begin
                        n_ops[n] = d.e1;
                        n = n + 2'd1;
                    end
                    if (d.r == 2'd2) begin
                        do_b = 1'b0;
                    end else if (d.r == 2'd1) begin
                        s = f_hunt(s, i_rx_byte);
                        do_b = 1'b0;
                    end
                end
            end
            if (do_b) begin
                if (i_rx_byte == SYM_ESC) begin
                    s.pend = 1'b1;
                end else begin
                    d = f_decode(s, i_rx_byte);
                    s = d.st;
                    n_ops[n] = d.e0;
                    n = n + 2'd1;
                    if (d.two) begin
                        n_ops[n] = d.e1;
                        n = n + 2'd1;
                    end
                end
            end
        end else begin
            s = f_hunt(s, i_rx_byte);
        end
        if (n != 2'd0) n_ops[n - 2'd1].last = 1'b1;
        n_st   = s;
        n_left = n;
    end

    assign o_full    = (r_left > 2'd1) || (r_left == 2'd1 && i_op_full);
    assign w_accept  = i_push && !o_full;
    assign w_drain   = (r_left != 2'd0) && !i_op_full;
    assign o_op_push = (r_left != 2'd0);
    assign o_op      = r_ops[r_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= '{hunt: H_WAIT_AA, pend: 1'b0, cnt: '0, len: '0};
            r_left <= '0;
            r_ptr  <= '0;
        end else if (w_accept) begin
            r_st   <= n_st;
            r_ops  <= n_ops;
            r_left <= n_left;
            r_ptr  <= '0;
        end else if (w_drain) begin
            r_left <= r_left - 2'd1;
            r_ptr  <= r_ptr + 2'd1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left != 2'd0 || r_ptr <= 2'd3)
        else $error("op pointer out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != 2'd0) |-> ({1'b0, r_ptr} + {1'b0, r_left} <= 3'd3))
        else $error("op list overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left == 2'd1 && o_op_push) |-> o_op.last)
        else $error("final op of a byte lacks last flag");

endmodule

[rtl/efr_back.sv]
// Back part: CRC-16 accumulation and frame status resolution.
`timescale 1ns / 1ps
module efr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  efr_pkg::t_evt i_op,
    input  logic          i_op_empty,
    output logic          o_op_pop,
    output logic          o_res_push,
    output efr_pkg::t_evt o_res,
    input  logic          i_res_full
);
    import efr_pkg::*;

    function automatic logic [15:0] f_crc_feed(logic [15:0] c, logic [7:0] v);
        logic [15:0] x;
        x = c ^ {8'h00, v};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    logic [15:0] r_crc, n_crc;
    logic [15:0] r_held, n_held;
    logic        w_go;

    assign w_go       = !i_op_empty && !i_res_full;
    assign o_op_pop   = w_go;
    assign o_res_push = w_go;

    always_comb begin
        o_res  = i_op;
        n_crc  = r_crc;
        n_held = r_held;
        case (i_op.kind)
            EK_DATA: begin
                if (i_op.idx >= 9'd2) n_crc = f_crc_feed(r_crc, r_held[15:8]);
                n_held = {r_held[7:0], i_op.data};
            end
            EK_GOOD: begin
                // The received CRC arrives low byte first.
                o_res.kind = ({r_held[7:0], r_held[15:8]} == r_crc) ? EK_GOOD : EK_CRCERR;
                n_crc  = CRC_INIT;
                n_held = '0;
            end
            default: begin
                n_crc  = CRC_INIT;
                n_held = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_held <= '0;
        end else if (w_go) begin
            r_crc  <= n_crc;
            r_held <= n_held;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && i_op.kind != EK_DATA) |=> (r_crc == CRC_INIT && r_held == '0))
        else $error("CRC state not cleared after frame event");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && i_op.kind == EK_DATA && i_op.idx < 9'd2) |=> (r_crc == CRC_INIT))
        else $error("CRC advanced on header bytes of frame");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_go |=> ($stable(r_crc) && $stable(r_held)))
        else $error("CRC state moved without an op");

endmodule

[rtl/escaped_frame_receiver_crc16_core.sv]
// Top level of the escaped frame receiver with CRC-16 check.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  rx byte  | in        | i_push / o_full       | i_rx_byte[7:0]
//  event    | out       | o_empty / i_pop       | o_event_kind, o_data_byte,
//           |           |                       | o_byte_index, o_last_of_run
//
// A byte is taken when o_full is low; the front part then hands its events (zero to three)
// to the op queue at one per cycle while the op queue has room, and holds off the next byte
// until its last event is going out. The back part also resolves one op per cycle while ops
// wait and the result queue has room, so events, not CRC work, set the rate.
// Synchronous active-low reset clears hunt state, counters and both queues.
// Either side may stall on its own: the op queue and the result queue absorb it.
`timescale 1ns / 1ps
module escaped_frame_receiver_crc16_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_rx_byte,
    output logic       o_full,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_data_byte,
    output logic [8:0] o_byte_index,
    output logic       o_last_of_run
);
    import efr_pkg::*;

    // front -> op queue
    t_evt w_fop;
    logic w_fop_push, w_opq_full;
    // op queue -> back
    t_evt w_bop;
    logic w_opq_empty, w_bop_pop;
    // back -> result queue
    t_evt w_res;
    logic w_res_push, w_resq_full;
    // result queue -> ports
    t_evt w_out;

    // Hunt for the header, unescape and classify each received byte.
    efr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_rx_byte (i_rx_byte),
        .o_full    (o_full),
        .o_op_push (w_fop_push),
        .o_op      (w_fop),
        .i_op_full (w_opq_full)
    );

    // Decouple classification from CRC work.
    efr_fifo u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fop_push),
        .i_data  (w_fop),
        .o_full  (w_opq_full),
        .i_pop   (w_bop_pop),
        .o_data  (w_bop),
        .o_empty (w_opq_empty)
    );

    // Run the CRC and turn frame ends into good or error status.
    efr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_bop),
        .i_op_empty (w_opq_empty),
        .o_op_pop   (w_bop_pop),
        .o_res_push (w_res_push),
        .o_res      (w_res),
        .i_res_full (w_resq_full)
    );

    // Hold finished results until the consumer pops them.
    efr_fifo u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_resq_full),
        .i_pop   (i_pop),
        .o_data  (w_out),
        .o_empty (o_empty)
    );

    assign o_event_kind  = w_out.kind;
    assign o_data_byte   = w_out.data;
    assign o_byte_index  = w_out.idx;
    assign o_last_of_run = w_out.last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_event_kind <= 3'd4))
        else $error("unknown event kind on output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_event_kind != EK_DATA) |-> (o_data_byte == 8'h00 && o_last_of_run))
        else $error("status transaction with data or without last flag");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_event_kind == EK_GOOD || o_event_kind == EK_CRCERR))
            |-> (o_byte_index >= 9'd3))
        else $error("frame status with too short a frame");

endmodule

[dv/tb.sv]
// Self-checking testbench for the escaped frame receiver with CRC-16 check.
`timescale 1ns / 1ps
module tb;
    import efr_pkg::*;

    // Hunt states of the predictor.
    localparam logic [1:0] HS_WAIT_ESC  = 2'd0;
    localparam logic [1:0] HS_WAIT_HDR  = 2'd1;
    localparam logic [1:0] HS_IN_FRAME  = 2'd2;

    // Outcome of decoding one byte.
    localparam int DEC_MORE = 0;
    localparam int DEC_END  = 1;
    localparam int DEC_OVF  = 2;

    localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on either side
    localparam int TAIL_CYCLES  = 20;
    localparam int RAND_ITEMS   = 105;

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       i_push     = 1'b0;
    logic [7:0] i_rx_byte  = 8'h00;
    logic       i_pop      = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [2:0] o_event_kind;
    logic [7:0] o_data_byte;
    logic [8:0] o_byte_index;
    logic       o_last_of_run;

    escaped_frame_receiver_crc16_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_rx_byte     (i_rx_byte),
        .o_full        (o_full),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_event_kind  (o_event_kind),
        .o_data_byte   (o_data_byte),
        .o_byte_index  (o_byte_index),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Frame decoder predictor: own copy of the hunt and frame state.
    // ------------------------------------------------------------------
    logic [1:0]  hs         = HS_WAIT_ESC;
    logic        esc_pend   = 1'b0;
    logic [8:0]  dec_cnt    = '0;
    logic [7:0]  frame_len  = '0;
    logic [15:0] crc_acc    = CRC_INIT;
    logic [15:0] tail_bytes = '0;  // last two decoded bytes, newest low

    t_evt ev_buf [3];
    int   ev_n;

    t_evt awaited_events [$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    int rand_items     = 0;
    int pop_left       = 0;
    int pop_mode       = 0;

    function automatic t_evt mk_evt(input t_kind k, input logic [7:0] d,
                                    input logic [8:0] i, input logic l);
        t_evt e;
        e.kind = k;
        e.data = d;
        e.idx  = i;
        e.last = l;
        return e;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] r;
        r = c ^ {8'h00, v};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void push_evt(input t_kind k, input logic [7:0] d, input logic [8:0] i);
        if (ev_n < 3) begin
            ev_buf[ev_n] = mk_evt(k, d, i, 1'b0);
            ev_n++;
        end
    endfunction

    function automatic void clear_frame_state();
        esc_pend   = 1'b0;
        dec_cnt    = '0;
        frame_len  = '0;
        crc_acc    = CRC_INIT;
        tail_bytes = '0;
    endfunction

    function automatic void hunt_step(input logic [7:0] b);
        if (hs == HS_WAIT_HDR) begin
            if (b == SYM_HDR) begin
                hs = HS_IN_FRAME;
                clear_frame_state();
            end else if (b != SYM_ESC) begin
                hs = HS_WAIT_ESC;
            end
        end else begin
            // the unused state falls in here as well
            hs = (b == SYM_ESC) ? HS_WAIT_HDR : HS_WAIT_ESC;
        end
    endfunction

    function automatic int decode_step(input logic [7:0] v);
        logic [9:0]  n_next;
        logic [15:0] recv;
        if (dec_cnt >= MAX_FRAME_BYTES) begin
            push_evt(EK_OVF, 8'h00, dec_cnt);
            hs = HS_WAIT_ESC;
            clear_frame_state();
            return DEC_OVF;
        end
        // the byte leaving the two-byte hold joins the CRC
        if (dec_cnt >= 2)
            crc_acc = crc16_byte(crc_acc, tail_bytes[15:8]);
        tail_bytes = {tail_bytes[7:0], v};
        if (dec_cnt == 0)
            frame_len = v;
        push_evt(EK_DATA, v, dec_cnt);
        n_next  = {1'b0, dec_cnt} + 10'd1;
        dec_cnt = n_next[8:0];
        if (n_next >= 10'd3 && n_next == {2'b00, frame_len} + 10'd3) begin
            recv = {tail_bytes[7:0], tail_bytes[15:8]};
            if (recv == crc_acc)
                push_evt(EK_GOOD, 8'h00, n_next[8:0]);
            else
                push_evt(EK_CRCERR, 8'h00, n_next[8:0]);
            hs = HS_WAIT_ESC;
            clear_frame_state();
            return DEC_END;
        end
        return DEC_MORE;
    endfunction

    // Advance the predictor by one raw byte; results land in ev_buf.
    function automatic void frame_decode_step(input logic [7:0] b);
        int r;
        ev_n = 0;
        if (hs == HS_IN_FRAME) begin
            if (esc_pend) begin
                esc_pend = 1'b0;
                if (b == SYM_LIT) begin
                    void'(decode_step(SYM_ESC));
                end else if (b == SYM_HDR) begin
                    push_evt(EK_RESTART, 8'h00, dec_cnt);
                    clear_frame_state();
                end else begin
                    // lone escape: it stands for itself, then handle b
                    r = decode_step(SYM_ESC);
                    if (r == DEC_END) begin
                        hunt_step(b);
                    end else if (r == DEC_MORE) begin
                        if (b == SYM_ESC)
                            esc_pend = 1'b1;
                        else
                            void'(decode_step(b));
                    end
                end
            end else if (b == SYM_ESC) begin
                esc_pend = 1'b1;
            end else begin
                void'(decode_step(b));
            end
        end else begin
            hunt_step(b);
        end
        if (ev_n > 0)
            ev_buf[ev_n-1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40)
            $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Event side: stall pattern, compare, and activity tracking.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_evt e;
        // Pick a new stall mode for each stretch: free run, coin flip,
        // one in four, or a long stall followed by a short run.
        if (pop_left == 0) begin
            pop_mode = $urandom_range(0, 3);
            pop_left = $urandom_range(16, 64);
        end
        pop_left--;
        case (pop_mode)
            0: begin
                i_pop <= 1'b1;
            end
            1: begin
                i_pop <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_pop <= (pop_left % 4 == 0);
            end
            default: begin
                i_pop <= (pop_left < 8);
            end
        endcase

        if (i_rst_n && i_pop && !o_empty) begin
            if (awaited_events.size() == 0) begin
                report_mismatch("event with none awaited, kind", o_event_kind, 0);
            end else begin
                e = awaited_events.pop_front();
                if (o_event_kind !== e.kind)
                    report_mismatch("event_kind", o_event_kind, e.kind);
                if (o_data_byte !== e.data)
                    report_mismatch("data_byte", o_data_byte, e.data);
                if (o_byte_index !== e.idx)
                    report_mismatch("byte_index", o_byte_index, e.idx);
                if (o_last_of_run !== e.last)
                    report_mismatch("last_of_run", o_last_of_run, e.last);
            end
        end

        // Count cycles in which neither side completes a transaction.
        if (i_rst_n && ((i_pop && !o_empty) || (i_push && !o_full)))
            idle_cycles = 0;
        else if (i_rst_n)
            idle_cycles++;
    end

    // Watchdog: end the run if the block stops moving.
    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte side.
    // ------------------------------------------------------------------

    // Drive one byte and hold it until the block takes it. Bursts of random
    // length are separated by random gaps; a zero gap keeps push high.
    task automatic drive_byte(input logic [7:0] b);
        int g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            g = $urandom_range(0, 6);
            if (g > 0) begin
                i_push <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        burst_left--;
        i_push    <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        drive_byte(b);
        frame_decode_step(b);
        for (int k = 0; k < ev_n; k++)
            awaited_events.push_back(ev_buf[k]);
        rand_items++;
    endtask

    // Send a decoded byte with the escape applied.
    task automatic send_coded(input logic [7:0] b);
        if (b == SYM_ESC) begin
            send_byte(SYM_ESC);
            send_byte(SYM_LIT);
        end else begin
            send_byte(b);
        end
    endtask

    task automatic send_header();
        send_byte(SYM_ESC);
        send_byte(SYM_HDR);
    endtask

    // Payload bytes lean toward the escape symbol.
    function automatic logic [7:0] rand_payload();
        if ($urandom_range(0, 5) == 0)
            return SYM_ESC;
        return 8'($urandom_range(0, 255));
    endfunction

    // Build a complete frame, append its CRC (optionally damaged), and send it.
    task automatic send_frame(input logic [7:0] len, input bit corrupt);
        logic [7:0]  body [$];
        logic [15:0] c;
        body.push_back(len);
        for (int i = 0; i < len; i++)
            body.push_back(rand_payload());
        c = CRC_INIT;
        foreach (body[i])
            c = crc16_byte(c, body[i]);
        if (corrupt)
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        send_header();
        foreach (body[i])
            send_coded(body[i]);
    endtask

    // Hold off new bytes until every awaited event has come out.
    task automatic drain_events();
        i_push     <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (awaited_events.size() != 0)
            @(posedge i_clk);
    endtask

    typedef struct {
        logic [7:0] b;
        bit         typed;  // expectation typed in the table, else predicted
        int         n;
        t_evt       ev0;
        t_evt       ev1;
    } t_dir_row;

    t_dir_row dir_rows [$];

    function automatic void add_row(input logic [7:0] b, input bit typed, input int n,
                                    input t_evt ev0 = '0, input t_evt ev1 = '0);
        t_dir_row r;
        r.b     = b;
        r.typed = typed;
        r.n     = n;
        r.ev0   = ev0;
        r.ev1   = ev1;
        dir_rows.push_back(r);
    endfunction

    initial begin
        int  sel;
        bit  drained_once;
        logic [7:0] len;

        // Hunting: extremes are ignored, repeated escape keeps waiting for the header.
        add_row(8'h00, 1, 0);
        add_row(8'hFF, 1, 0);
        add_row(SYM_ESC, 1, 0);
        add_row(SYM_ESC, 1, 0);
        add_row(SYM_HDR, 1, 0);
        // Shortest frame: length 0, CRC of a single zero byte is 0x40BF.
        add_row(8'h00, 1, 1, mk_evt(EK_DATA, 8'h00, 9'd0, 1'b1));
        add_row(8'hBF, 1, 1, mk_evt(EK_DATA, 8'hBF, 9'd1, 1'b1));
        add_row(8'h40, 1, 2, mk_evt(EK_DATA, 8'h40, 9'd2, 1'b0),
                             mk_evt(EK_GOOD, 8'h00, 9'd3, 1'b1));
        // Escaped literal, lone escape, then header inside the frame.
        add_row(SYM_ESC, 1, 0);
        add_row(SYM_HDR, 1, 0);
        add_row(8'h02, 1, 1, mk_evt(EK_DATA, 8'h02, 9'd0, 1'b1));
        add_row(SYM_ESC, 1, 0);
        add_row(SYM_LIT, 1, 1, mk_evt(EK_DATA, SYM_ESC, 9'd1, 1'b1));
        add_row(SYM_ESC, 1, 0);
        add_row(8'h33, 1, 2, mk_evt(EK_DATA, SYM_ESC, 9'd2, 1'b0),
                             mk_evt(EK_DATA, 8'h33, 9'd3, 1'b1));
        add_row(SYM_ESC, 1, 0);
        add_row(SYM_HDR, 1, 1, mk_evt(EK_RESTART, 8'h00, 9'd4, 1'b1));
        // Frame that ends on a lone escape; the byte after it is hunted.
        add_row(8'h01, 1, 1, mk_evt(EK_DATA, 8'h01, 9'd0, 1'b1));
        add_row(8'hFF, 1, 1, mk_evt(EK_DATA, 8'hFF, 9'd1, 1'b1));
        add_row(8'h12, 1, 1, mk_evt(EK_DATA, 8'h12, 9'd2, 1'b1));
        add_row(SYM_ESC, 1, 0);
        add_row(SYM_ESC, 0, 0);
        add_row(SYM_HDR, 1, 0);

        // Reset once, then release it.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: typed rows push the table's events, others the predictor's.
        foreach (dir_rows[r]) begin
            drive_byte(dir_rows[r].b);
            frame_decode_step(dir_rows[r].b);
            if (dir_rows[r].typed) begin
                if (dir_rows[r].n > 0)
                    awaited_events.push_back(dir_rows[r].ev0);
                if (dir_rows[r].n > 1)
                    awaited_events.push_back(dir_rows[r].ev1);
            end else begin
                for (int k = 0; k < ev_n; k++)
                    awaited_events.push_back(ev_buf[k]);
            end
        end
        drain_events();

        // Random part: mostly well-formed frames, the rest broken frames and noise.
        drained_once = 1'b0;
        while (rand_items < RAND_ITEMS) begin
            if (!drained_once && rand_items >= RAND_ITEMS / 2) begin
                drain_events();
                drained_once = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                if ($urandom_range(0, 9) == 0)
                    len = 8'($urandom_range(11, 40));
                else
                    len = 8'($urandom_range(0, 10));
                send_frame(len, sel >= 60);
            end else if (sel < 80) begin
                // truncated frame; the next header restarts it
                send_header();
                len = 8'($urandom_range(2, 20));
                send_coded(len);
                repeat ($urandom_range(0, len)) send_coded(rand_payload());
            end else if (sel < 88) begin
                // lone escape followed by an arbitrary byte
                send_header();
                send_coded(8'($urandom_range(3, 9)));
                send_coded(rand_payload());
                send_byte(SYM_ESC);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0: send_byte(SYM_ESC);
                        1: send_byte(SYM_HDR);
                        2: send_byte(SYM_LIT);
                        default: send_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
        end

        // Wait for every awaited event, then let the pipeline settle.
        drain_events();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_events.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
